// ----- design/forward_time_window_event_builder_unit_assert.svh -----
// Assertion helpers for the event builder.
`ifndef FORWARD_TIME_WINDOW_EVENT_BUILDER_UNIT_ASSERT_SVH
`define FORWARD_TIME_WINDOW_EVENT_BUILDER_UNIT_ASSERT_SVH

// Property checked at every edge outside reset.
`define FTWEB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FTWEB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ftweb_pkg.sv -----
package ftweb_pkg;

    localparam int CH_W  = 4;
    localparam int TS_W  = 48;
    localparam int EN_W  = 16;
    localparam int EVN_W = 16;
    localparam int WIN_W = 32;

    localparam logic [1:0] REG_TIME_WINDOW   = 2'd0;
    localparam logic [1:0] REG_LEFTOVER_TIME = 2'd1;
    localparam logic [1:0] REG_BREAK_TIME    = 2'd2;

    localparam logic [WIN_W-1:0] WINDOW_RESET   = 32'd100;
    localparam logic [WIN_W-1:0] LEFTOVER_RESET = 32'd100;
    localparam logic [TS_W-1:0]  BREAK_RESET    = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN0,
        S_CHECK,
        S_JUDGE,
        S_POP,
        S_REFILL,
        S_SCAN,
        S_RD,
        S_LOAD,
        S_SEND
    } t_state;

    typedef struct packed {
        logic [CH_W-1:0] chan;
        logic [TS_W-1:0] ts;
        logic [EN_W-1:0] energy;
    } t_hit;

    typedef struct packed {
        logic [WIN_W-1:0] time_window;
        logic [WIN_W-1:0] leftover_time;
        logic [TS_W-1:0]  break_time;
    } t_cfg;

    typedef struct packed {
        logic push;
        logic start;
        logic scan_clr;
        logic scan_en;
        logic seed_ld;
        logic set_trunc;
        logic pop;
        logic head_ld;
        logic obuf_rd;
        logic out_ld;
        logic obuf_next;
        logic evt_done;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic have_best;
        logic proceed;
        logic join_ok;
        logic limit_hit;
        logic win_zero;
        logic buf_last;
        logic out_taken;
    } t_sts;

endpackage

// ----- design/ftweb_if.sv -----
interface ftweb_hit_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  channel;
    logic [47:0] timestamp;
    logic [15:0] energy;
    logic        final_req;

    modport source (output valid, kind, channel, timestamp, energy, final_req, input ready);
    modport sink (input valid, kind, channel, timestamp, energy, final_req, output ready);
endinterface

interface ftweb_evt_if;
    logic        valid;
    logic        ready;
    logic [15:0] event_number;
    logic [3:0]  hit_channel;
    logic [47:0] hit_time;
    logic [15:0] hit_energy;
    logic        last_hit;
    logic        truncated;
    logic        overflowed;

    modport source (output valid, event_number, hit_channel, hit_time, hit_energy, last_hit,
                    truncated, overflowed, input ready);
    modport sink (input valid, event_number, hit_channel, hit_time, hit_energy, last_hit,
                  truncated, overflowed, output ready);
endinterface

// ----- design/ftweb_ctrl.sv -----
module ftweb_ctrl
    import ftweb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_kind,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_kind) n_state = S_SCAN0;
            end
            S_SCAN0: begin
                if (i_sts.scan_last) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = (i_sts.have_best && i_sts.proceed) ? S_JUDGE : S_IDLE;
            end
            S_JUDGE: begin
                priority if (!(i_sts.have_best && i_sts.join_ok)) n_state = S_RD;
                else if (i_sts.limit_hit) n_state = S_RD;
                else n_state = S_POP;
            end
            S_POP: n_state = S_REFILL;
            S_REFILL: begin
                n_state = i_sts.win_zero ? S_RD : S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_last) n_state = S_JUDGE;
            end
            S_RD: n_state = S_LOAD;
            S_LOAD: n_state = S_SEND;
            S_SEND: begin
                if (i_sts.out_taken) n_state = i_sts.buf_last ? S_IDLE : S_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.push  = i_in_valid && !i_in_kind;
                o_cmd.start = i_in_valid && i_in_kind;
            end
            S_SCAN0, S_SCAN: o_cmd.scan_en = 1'b1;
            S_CHECK: o_cmd.seed_ld = 1'b1;
            S_JUDGE: begin
                o_cmd.set_trunc = i_sts.have_best && i_sts.join_ok && i_sts.limit_hit;
            end
            S_POP: o_cmd.pop = 1'b1;
            S_REFILL: begin
                o_cmd.head_ld  = 1'b1;
                o_cmd.scan_clr = 1'b1;
            end
            S_RD: o_cmd.obuf_rd = 1'b1;
            S_LOAD: o_cmd.out_ld = 1'b1;
            S_SEND: begin
                o_cmd.evt_done  = i_sts.out_taken && i_sts.buf_last;
                o_cmd.obuf_next = i_sts.out_taken && !i_sts.buf_last;
            end
            default: ;
        endcase
    end

endmodule

// ----- design/ftweb_dp.sv -----
`include "forward_time_window_event_builder_unit_assert.svh"

module ftweb_dp
    import ftweb_pkg::*;
#(
    parameter int CHANNELS        = 16,
    parameter int FIFO_DEPTH      = 16,
    parameter int EVENT_HIT_LIMIT = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  t_cfg             i_cfg,
    input  logic [CH_W-1:0]  i_channel,
    input  logic [TS_W-1:0]  i_timestamp,
    input  logic [EN_W-1:0]  i_energy,
    input  logic             i_final_req,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [EVN_W-1:0] o_event_number,
    output logic [CH_W-1:0]  o_hit_channel,
    output logic [TS_W-1:0]  o_hit_time,
    output logic [EN_W-1:0]  o_hit_energy,
    output logic             o_last_hit,
    output logic             o_truncated,
    output logic             o_overflowed
);

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SW    = CNT_W + 1;
    localparam int AW    = $clog2(CHANNELS * FIFO_DEPTH);
    localparam int MD    = CHANNELS * FIFO_DEPTH;
    localparam int BW    = (EVENT_HIT_LIMIT > 1) ? $clog2(EVENT_HIT_LIMIT) : 1;
    localparam int NW    = $clog2(EVENT_HIT_LIMIT + 1);

    logic [CNT_W-1:0]     r_count [CHANNELS];
    logic [PW-1:0]        r_rd [CHANNELS];
    logic [TS_W-1:0]      r_latest [CHANNELS];
    logic [CHANNELS-1:0]  r_seen;
    logic [TS_W-1:0]      r_head_ts [CHANNELS];
    logic [EN_W-1:0]      r_head_en [CHANNELS];
    logic [TS_W+EN_W-1:0] r_mem [MD];
    logic [TS_W+EN_W-1:0] r_mem_q;
    t_hit                 r_ebuf [EVENT_HIT_LIMIT];
    t_hit                 r_buf_q;
    t_hit                 r_out;
    logic                 r_out_last;
    logic                 r_out_valid;

    logic [CW-1:0]        r_scan_idx;
    logic                 r_have_best;
    logic [CW-1:0]        r_best_ch;
    logic [TS_W-1:0]      r_best_ts;
    logic                 r_have_lim;
    logic [TS_W-1:0]      r_safe_ts;
    logic [TS_W-1:0]      r_seed;
    logic                 r_final;
    logic [NW-1:0]        r_n;
    logic [NW-1:0]        r_k;
    logic                 r_trunc;
    logic                 r_ovf;
    logic [EVN_W-1:0]     r_evt_cnt;
    logic [CW-1:0]        r_pop_ch;
    logic                 r_refill;

    logic [6:0]       chan7;
    logic [CW-1:0]    p_idx;
    logic             in_range;
    logic [CW-1:0]    ix;
    logic [6:0]       ix7;
    logic [CNT_W-1:0] cnt_ix;
    logic [PW-1:0]    rd_ix;
    logic [SW-1:0]    wr_sum;
    logic [PW-1:0]    wr_ptr;
    logic [PW-1:0]    rd_next;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             push_ok;
    logic             push_full;
    logic             scan_clr;
    logic [TS_W-1:0]  safe_diff;
    logic [TS_W-1:0]  win_diff;
    logic             in_left;

    assign chan7    = 7'(i_channel);
    assign p_idx    = chan7[CW-1:0];
    assign in_range = chan7 < 7'(CHANNELS);

    always_comb begin
        priority if (i_cmd.scan_en) ix = r_scan_idx;
        else if (i_cmd.pop) ix = r_best_ch;
        else ix = p_idx;
    end

    assign ix7     = 7'(ix);
    assign cnt_ix  = r_count[ix];
    assign rd_ix   = r_rd[ix];
    assign wr_sum  = SW'(rd_ix) + SW'(cnt_ix);
    assign wr_ptr  = (wr_sum >= SW'(FIFO_DEPTH)) ? PW'(wr_sum - SW'(FIFO_DEPTH)) : PW'(wr_sum);
    assign rd_next = (rd_ix == PW'(FIFO_DEPTH - 1)) ? '0 : PW'(rd_ix + 1'b1);
    assign wr_addr = AW'(ix) * AW'(FIFO_DEPTH) + AW'(wr_ptr);
    assign rd_addr = AW'(ix) * AW'(FIFO_DEPTH) + AW'(rd_next);

    assign push_full = cnt_ix == CNT_W'(FIFO_DEPTH);
    assign push_ok   = i_cmd.push && in_range && (i_timestamp != '0) && !push_full;
    assign scan_clr  = i_cmd.scan_clr || i_cmd.start;

    assign safe_diff = r_safe_ts - r_best_ts;
    assign win_diff  = r_best_ts - r_seed;
    assign in_left   = (r_safe_ts >= r_best_ts) && (safe_diff <= TS_W'(i_cfg.leftover_time));

    assign o_sts.scan_last = r_scan_idx == CW'(CHANNELS - 1);
    assign o_sts.have_best = r_have_best;
    assign o_sts.proceed   = r_final
                             || (r_have_lim && !in_left && !(r_best_ts > i_cfg.break_time));
    assign o_sts.join_ok   = (r_best_ts >= r_seed) && (win_diff <= TS_W'(i_cfg.time_window));
    assign o_sts.limit_hit = r_n == NW'(EVENT_HIT_LIMIT);
    assign o_sts.win_zero  = i_cfg.time_window == '0;
    assign o_sts.buf_last  = r_out_last;
    assign o_sts.out_taken = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[wr_addr] <= {i_timestamp, i_energy};
        end
        if (i_cmd.pop) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok && (cnt_ix == '0)) begin
            r_head_ts[ix] <= i_timestamp;
            r_head_en[ix] <= i_energy;
        end
        if (i_cmd.head_ld && r_refill) begin
            r_head_ts[r_pop_ch] <= r_mem_q[TS_W+EN_W-1:EN_W];
            r_head_en[r_pop_ch] <= r_mem_q[EN_W-1:0];
        end
        if (i_cmd.pop) begin
            r_ebuf[r_n[BW-1:0]] <= '{chan: ix7[3:0], ts: r_head_ts[ix], energy: r_head_en[ix]};
        end
        if (i_cmd.obuf_rd) begin
            r_buf_q <= r_ebuf[r_k[BW-1:0]];
        end
        if (i_cmd.out_ld) begin
            r_out      <= r_buf_q;
            r_out_last <= r_k == NW'(r_n - 1'b1);
        end
        if (i_cmd.seed_ld) begin
            r_seed <= r_best_ts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_count[c]  <= '0;
                r_rd[c]     <= '0;
                r_latest[c] <= '0;
            end
            r_seen      <= '0;
            r_scan_idx  <= '0;
            r_have_best <= 1'b0;
            r_best_ch   <= '0;
            r_best_ts   <= '0;
            r_have_lim  <= 1'b0;
            r_safe_ts   <= '0;
            r_final     <= 1'b0;
            r_n         <= '0;
            r_k         <= '0;
            r_trunc     <= 1'b0;
            r_ovf       <= 1'b0;
            r_evt_cnt   <= '0;
            r_pop_ch    <= '0;
            r_refill    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push && in_range && (i_timestamp != '0) && push_full) begin
                r_ovf <= 1'b1;
            end
            if (push_ok) begin
                r_count[ix]  <= CNT_W'(cnt_ix + 1'b1);
                r_latest[ix] <= i_timestamp;
                r_seen[ix]   <= 1'b1;
            end
            if (i_cmd.start) begin
                r_final <= i_final_req;
                r_n     <= '0;
                r_k     <= '0;
                r_trunc <= 1'b0;
            end
            if (scan_clr) begin
                r_scan_idx  <= '0;
                r_have_best <= 1'b0;
                r_have_lim  <= 1'b0;
            end else if (i_cmd.scan_en) begin
                r_scan_idx <= CW'(r_scan_idx + 1'b1);
                if ((cnt_ix != '0) && (!r_have_best || (r_head_ts[ix] < r_best_ts))) begin
                    r_have_best <= 1'b1;
                    r_best_ch   <= ix;
                    r_best_ts   <= r_head_ts[ix];
                end
                if (r_seen[ix] && (!r_have_lim || (r_latest[ix] < r_safe_ts))) begin
                    r_have_lim <= 1'b1;
                    r_safe_ts  <= r_latest[ix];
                end
            end
            if (i_cmd.set_trunc) begin
                r_trunc <= 1'b1;
            end
            if (i_cmd.pop) begin
                r_count[ix] <= CNT_W'(cnt_ix - 1'b1);
                r_rd[ix]    <= rd_next;
                r_pop_ch    <= ix;
                r_refill    <= cnt_ix != CNT_W'(1);
                r_n         <= NW'(r_n + 1'b1);
            end
            if (i_cmd.obuf_next) begin
                r_k <= NW'(r_k + 1'b1);
            end
            if (i_cmd.evt_done) begin
                r_evt_cnt <= EVN_W'(r_evt_cnt + 1'b1);
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_number = r_evt_cnt;
    assign o_hit_channel  = r_out.chan;
    assign o_hit_time     = r_out.ts;
    assign o_hit_energy   = r_out.energy;
    assign o_last_hit     = r_out_last;
    assign o_truncated    = r_trunc;
    assign o_overflowed   = r_ovf;

    `FTWEB_ASSERT(a_pop_has_best, i_clk, i_rst_n, i_cmd.pop |-> r_have_best, "pop without head")
    `FTWEB_ASSERT(a_n_bound, i_clk, i_rst_n, r_n <= NW'(EVENT_HIT_LIMIT), "hit count past limit")
    `FTWEB_ASSERT_NEXT(a_ovf_sticky, i_clk, i_rst_n, r_ovf, r_ovf, "overflow flag cleared")
    `FTWEB_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, i_cmd.pop, r_n == $past(r_n) + 1'b1, "pop lost")

endmodule

// ----- design/forward_time_window_event_builder_unit.sv -----
// Channel   Direction  Protocol     Payload
// i_hit     in         valid/ready  kind, channel, timestamp, energy, final_req
// o_evt     out        valid/ready  event_number, hit_channel, hit_time, hit_energy,
//                                   last_hit, truncated, overflowed
// APB       in         psel/penable time_window, leftover_time, break_time (8-byte stride)
//
// A push request is taken while idle. A build request first scans every channel and checks
// the oldest head, then for each collected hit judges it, pops it, refills that FIFO head
// from memory and rescans the FIFO heads (no rescan with a zero window), plus one closing
// judge, then reads, loads and sends each hit to stream the event buffer out.
// Synchronous active-low reset clears all FIFO counts, flags and counters; no clearing pass.
// A stalled output holds the builder; no new request is taken until the event is drained.
module forward_time_window_event_builder_unit
    import ftweb_pkg::*;
#(
    parameter int CHANNELS        = 16,
    parameter int FIFO_DEPTH      = 16,
    parameter int EVENT_HIT_LIMIT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ftweb_hit_if.sink   i_hit,
    ftweb_evt_if.source o_evt,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output logic [63:0] o_prdata,
    output logic        o_pready
);

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_window   <= WINDOW_RESET;
            r_cfg.leftover_time <= LEFTOVER_RESET;
            r_cfg.break_time    <= BREAK_RESET;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (i_paddr[4:3])
                REG_TIME_WINDOW:   r_cfg.time_window   <= i_pwdata[WIN_W-1:0];
                REG_LEFTOVER_TIME: r_cfg.leftover_time <= i_pwdata[WIN_W-1:0];
                REG_BREAK_TIME:    r_cfg.break_time    <= i_pwdata[TS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[4:3])
            REG_TIME_WINDOW:   o_prdata = 64'(r_cfg.time_window);
            REG_LEFTOVER_TIME: o_prdata = 64'(r_cfg.leftover_time);
            REG_BREAK_TIME:    o_prdata = 64'(r_cfg.break_time);
            default:           o_prdata = '0;
        endcase
    end

    assign o_pready = 1'b1;

    ftweb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_hit.valid),
        .i_in_kind  (i_hit.kind),
        .o_in_ready (i_hit.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ftweb_dp #(
        .CHANNELS        (CHANNELS),
        .FIFO_DEPTH      (FIFO_DEPTH),
        .EVENT_HIT_LIMIT (EVENT_HIT_LIMIT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg          (r_cfg),
        .i_channel      (i_hit.channel),
        .i_timestamp    (i_hit.timestamp),
        .i_energy       (i_hit.energy),
        .i_final_req    (i_hit.final_req),
        .i_out_ready    (o_evt.ready),
        .o_out_valid    (o_evt.valid),
        .o_event_number (o_evt.event_number),
        .o_hit_channel  (o_evt.hit_channel),
        .o_hit_time     (o_evt.hit_time),
        .o_hit_energy   (o_evt.hit_energy),
        .o_last_hit     (o_evt.last_hit),
        .o_truncated    (o_evt.truncated),
        .o_overflowed   (o_evt.overflowed)
    );

endmodule

// ----- test/forward_time_window_event_builder_unit_tb.sv -----
`timescale 1ns / 1ps

module forward_time_window_event_builder_unit_tb
    import ftweb_pkg::*;
;

    localparam int NCH = 16;
    localparam int DEPTH = 16;
    localparam int HIT_LIMIT = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 100;
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_BUILD = 1'b1;

    typedef struct packed {
        logic [TS_W-1:0] ts;
        logic [EN_W-1:0] energy;
    } t_slot;

    typedef struct packed {
        logic [EVN_W-1:0] event_number;
        logic [CH_W-1:0]  hit_channel;
        logic [TS_W-1:0]  hit_time;
        logic [EN_W-1:0]  hit_energy;
        logic             last_hit;
        logic             truncated;
        logic             overflowed;
    } t_evt_hit;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_psel, i_penable, i_pwrite;
    logic [4:0] i_paddr;
    logic [63:0] i_pwdata;
    logic [63:0] o_prdata;
    logic o_pready;

    ftweb_hit_if hit ();
    ftweb_evt_if evt ();

    forward_time_window_event_builder_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_hit(hit), .o_evt(evt),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata), .o_prdata(o_prdata), .o_pready(o_pready)
    );

    always #2 i_clk = ~i_clk;

    t_slot lane_q[NCH][$];
    logic [TS_W-1:0] lane_latest[NCH];
    bit lane_seen[NCH];
    logic [EVN_W-1:0] events_built;
    bit dropped_flag;
    logic [WIN_W-1:0] window_cfg;
    logic [WIN_W-1:0] leftover_cfg;
    logic [TS_W-1:0] break_cfg;

    t_evt_hit event_hits_due[$];
    int errors = 0;
    int src_idle = 38;
    int snk_idle = 67;
    int stall_cycles = 0;
    int quiet_cycles = 0;
    logic [TS_W-1:0] clock_ts = 48'd1000;

    function automatic int oldest_lane();
        int best = -1;
        for (int c = 0; c < NCH; c++) begin
            if (lane_q[c].size() == 0) continue;
            if (best < 0 || lane_q[c][0].ts < lane_q[best][0].ts) best = c;
        end
        return best;
    endfunction

    function automatic void predict_build(bit fin);
        int first, c, n;
        bit have_safe, cut;
        logic [TS_W-1:0] seed, safe, hts;
        t_slot s;
        t_evt_hit h;
        t_evt_hit ev[$];
        first = oldest_lane();
        if (first < 0) return;
        seed = lane_q[first][0].ts;
        if (!fin) begin
            have_safe = 0;
            safe = '0;
            for (int k = 0; k < NCH; k++) begin
                if (lane_seen[k] && (!have_safe || lane_latest[k] < safe)) begin
                    safe = lane_latest[k];
                    have_safe = 1;
                end
            end
            if (!have_safe) return;
            if (safe >= seed && (safe - seed) <= {16'd0, leftover_cfg}) return;
            if (seed > break_cfg) return;
        end
        n = 0;
        cut = 0;
        forever begin
            c = oldest_lane();
            if (c < 0) break;
            hts = lane_q[c][0].ts;
            if (hts < seed || (hts - seed) > {16'd0, window_cfg}) break;
            if (n >= HIT_LIMIT) begin
                cut = 1;
                break;
            end
            s = lane_q[c].pop_front();
            h = '{events_built, c[CH_W-1:0], s.ts, s.energy, 1'b0, 1'b0, dropped_flag};
            ev.insert(ev.size(), h);
            n++;
            if (window_cfg == 0) break;
        end
        ev[n-1].last_hit = 1'b1;
        foreach (ev[k]) begin
            ev[k].truncated = cut;
            event_hits_due.insert(event_hits_due.size(), ev[k]);
        end
        events_built++;
    endfunction

    function automatic void predict_push(logic [CH_W-1:0] ch, logic [TS_W-1:0] ts,
                                         logic [EN_W-1:0] en);
        t_slot s;
        if (ts == 0) return;
        if (lane_q[ch].size() >= DEPTH) begin
            dropped_flag = 1;
            return;
        end
        s = '{ts, en};
        lane_q[ch].insert(lane_q[ch].size(), s);
        lane_latest[ch] = ts;
        lane_seen[ch] = 1;
    endfunction

    task automatic send_request(logic kind, logic [CH_W-1:0] ch, logic [TS_W-1:0] ts,
                                logic [EN_W-1:0] en, logic fin);
        bit took;
        while ($urandom_range(0, 99) < src_idle) begin
            hit.valid <= 1'b0;
            @(posedge i_clk);
        end
        hit.valid <= 1'b1;
        hit.kind <= kind;
        hit.channel <= ch;
        hit.timestamp <= ts;
        hit.energy <= en;
        hit.final_req <= fin;
        do begin
            @(negedge i_clk);
            took = hit.ready;
            @(posedge i_clk);
        end while (!took);
        if (kind == KIND_PUSH) predict_push(ch, ts, en);
        else predict_build(fin);
    endtask

    task automatic push(int ch, logic [TS_W-1:0] ts, logic [EN_W-1:0] en);
        send_request(KIND_PUSH, ch[CH_W-1:0], ts, en, 1'b0);
    endtask

    task automatic build(bit fin);
        send_request(KIND_BUILD, CH_W'($urandom), TS_W'({$urandom, $urandom}),
                     EN_W'($urandom), fin);
    endtask

    task automatic settle();
        hit.valid <= 1'b0;
        while (event_hits_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [63:0] value);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= {idx, 3'b000};
        i_pwdata <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        case (idx)
            REG_TIME_WINDOW:   window_cfg = value[WIN_W-1:0];
            REG_LEFTOVER_TIME: leftover_cfg = value[WIN_W-1:0];
            default:           break_cfg = value[TS_W-1:0];
        endcase
    endtask

    task automatic configure(logic [WIN_W-1:0] win, logic [WIN_W-1:0] left,
                             logic [TS_W-1:0] brk);
        settle();
        reg_write(REG_TIME_WINDOW, {32'd0, win});
        reg_write(REG_LEFTOVER_TIME, {32'd0, left});
        reg_write(REG_BREAK_TIME, {16'd0, brk});
    endtask

    task automatic drain_all();
        while (oldest_lane() >= 0) build(1'b1);
    endtask

    task automatic test_basic_builds();
        build(1'b0);
        build(1'b1);
        push(0, 48'd0, 16'hFFFF);
        push(0, 48'd10, 16'h0000);
        push(3, 48'd10, 16'hFFFF);
        push(1, 48'd50, 16'h1234);
        build(1'b0);
        push(0, 48'd500, 16'h0001);
        push(3, 48'd600, 16'h0002);
        push(1, 48'd700, 16'h0003);
        build(1'b0);
        push(4, 48'd20, 16'h0004);
        build(1'b1);
        build(1'b0);
        push(15, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        push(14, 48'hFFFF_FFFF_FFFE, 16'h8000);
        drain_all();
    endtask

    task automatic test_window_and_break();
        configure(32'd0, 32'd0, 48'd0);
        push(2, 48'd100, 16'hAAAA);
        push(5, 48'd100, 16'h5555);
        push(2, 48'd5000, 16'h0F0F);
        push(5, 48'd6000, 16'hF0F0);
        build(1'b0);
        build(1'b1);
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        build(1'b0);
        drain_all();
    endtask

    // Leave channel 7 full; the hit limit test drains it.
    task automatic test_overflow();
        configure(32'd100, 32'd100, 48'hFFFF_FFFF_FFFF);
        for (int k = 0; k < DEPTH + 1; k++) push(7, TS_W'(2000 + k), EN_W'($urandom));
    endtask

    task automatic test_hit_limit();
        configure(32'hFFFF_FFFF, 32'd100, 48'hFFFF_FFFF_FFFF);
        for (int k = 0; k < 12; k++)
            for (int c = 8; c < 12; c++) push(c, TS_W'(3000 + k), EN_W'($urandom));
        push(12, 48'd3100, EN_W'($urandom));
        drain_all();
    endtask

    task automatic test_backpressure();
        stall_cycles = 400;
        for (int k = 0; k < 8; k++) begin
            clock_ts += $urandom_range(1, 5);
            push($urandom_range(0, 3), clock_ts, EN_W'($urandom));
            if (k % 4 == 3) build(1'b1);
        end
        drain_all();
    endtask

    task automatic random_phase(int items);
        int pick;
        for (int k = 0; k < items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                clock_ts += $urandom_range(1, 80);
                push($urandom_range(0, 7), clock_ts, EN_W'($urandom));
            end else if (pick < 90) begin
                build($urandom_range(0, 2) == 0);
            end else if (pick < 95) begin
                push($urandom_range(0, 15), {16'($urandom), $urandom}, EN_W'($urandom));
            end else begin
                push($urandom_range(0, 15), 48'd0, EN_W'($urandom));
            end
        end
        drain_all();
    endtask

    task automatic test_random();
        src_idle = 38;
        snk_idle = 67;
        configure(WIN_W'($urandom_range(0, 300)), WIN_W'($urandom_range(0, 300)),
                  48'hFFFF_FFFF_FFFF);
        random_phase(5);
        src_idle = 67;
        snk_idle = 38;
        configure(32'hFFFF_FFFF, 32'd0, {16'($urandom), $urandom});
        random_phase(5);
        src_idle = 0;
        snk_idle = 0;
        configure(WIN_W'($urandom_range(1, 150)), 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        random_phase(5);
    endtask

    initial begin
        t_evt_hit got, want;
        bit took;
        evt.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            took = evt.valid && evt.ready;
            got = '{evt.event_number, evt.hit_channel, evt.hit_time, evt.hit_energy,
                    evt.last_hit, evt.truncated, evt.overflowed};
            @(posedge i_clk);
            if (took) begin
                if (event_hits_due.size() == 0) begin
                    errors++;
                    $display("%0t unexpected event hit: expected none actual %p", $time, got);
                end else begin
                    want = event_hits_due.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t mismatch: expected %p actual %p", $time, want, got);
                    end
                end
            end
            if (stall_cycles > 0) begin
                stall_cycles--;
                evt.ready <= 1'b0;
            end else begin
                evt.ready <= $urandom_range(0, 99) >= snk_idle;
            end
        end
    end

    initial begin
        bit busy;
        forever begin
            @(negedge i_clk);
            busy = (hit.valid && hit.ready) || (evt.valid && evt.ready);
            @(posedge i_clk);
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        hit.valid = 1'b0;
        hit.kind = KIND_PUSH;
        hit.channel = '0;
        hit.timestamp = '0;
        hit.energy = '0;
        hit.final_req = 1'b0;
        for (int c = 0; c < NCH; c++) begin
            lane_latest[c] = '0;
            lane_seen[c] = 0;
        end
        events_built = '0;
        dropped_flag = 0;
        window_cfg = WINDOW_RESET;
        leftover_cfg = LEFTOVER_RESET;
        break_cfg = BREAK_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_builds();
        test_window_and_break();
        test_overflow();
        test_hit_limit();
        test_backpressure();
        test_random();
        settle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- forward_time_window_event_builder_unit.f -----
+incdir+design
design/ftweb_pkg.sv
design/ftweb_if.sv
design/ftweb_ctrl.sv
design/ftweb_dp.sv
design/forward_time_window_event_builder_unit.sv
test/forward_time_window_event_builder_unit_tb.sv
